@@ sv/mpp_pkg.sv @@
`default_nettype none
package mpp_pkg;
    localparam logic [7:0] SYNC_MARK = 8'hAA;
    localparam logic [7:0] STR_MAX = 8'd254;

    typedef enum logic [4:0] {
        PH_SYNC1, PH_SYNC2, PH_HUNT, PH_TYPE, PH_LEN, PH_COUNT, PH_STREAM,
        PH_SEQTAG, PH_SEQVAL, PH_TSTAG, PH_TSVAL, PH_VTAG, PH_VDATA,
        PH_SLEN, PH_BLEN, PH_PAY, PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        KIND_START = 3'd0, KIND_SEQNO = 3'd1, KIND_TSTAMP = 3'd2,
        KIND_VALUE = 3'd3, KIND_PAYLOAD = 3'd4, KIND_ERROR = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SYNC = 3'd0, ERR_TYPE = 3'd1, ERR_NOVAL = 3'd2, ERR_TOOMANY = 3'd3,
        ERR_SEQTAG = 3'd4, ERR_TSTAG = 3'd5, ERR_TAG = 3'd6, ERR_BLOB = 3'd7
    } err_t;

    localparam logic [3:0] TAG_INT32A = 4'd1;
    localparam logic [3:0] TAG_DBL = 4'd2;
    localparam logic [3:0] TAG_DBLX = 4'd3;
    localparam logic [3:0] TAG_STR = 4'd4;
    localparam logic [3:0] TAG_INT32B = 4'd5;
    localparam logic [3:0] TAG_UINT32 = 4'd6;
    localparam logic [3:0] TAG_INT64 = 4'd7;
    localparam logic [3:0] TAG_UINT64 = 4'd8;
    localparam logic [3:0] TAG_BLOB = 4'd9;

    localparam logic [2:0] VT_INT32 = 3'd0;
    localparam logic [2:0] VT_UINT32 = 3'd1;
    localparam logic [2:0] VT_INT64 = 3'd2;
    localparam logic [2:0] VT_UINT64 = 3'd3;
    localparam logic [2:0] VT_DBL = 3'd4;
    localparam logic [2:0] VT_DBLX = 3'd5;
    localparam logic [2:0] VT_STRING = 3'd6;
    localparam logic [2:0] VT_BLOB = 3'd7;

    localparam logic [1:0] REG_MAXV = 2'd0;
    localparam logic [1:0] REG_SHORT = 2'd1;
    localparam logic [1:0] REG_LONG = 2'd2;

    typedef struct packed {
        logic [2:0]  rec_kind;
        logic [2:0]  value_type;
        logic [63:0] data_value;
        logic signed [7:0] exponent;
        logic [7:0]  stream_index;
        logic [7:0]  pkt_count;
        logic [7:0]  value_index;
        logic [2:0]  error_code;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [7:0] max_values;
        logic [7:0] short_type_code;
        logic [7:0] long_type_code;
    } cfg_t;

    function automatic logic [2:0] tag_type(input logic [3:0] tag);
        logic [2:0] r;
        begin
            unique case (tag)
                TAG_UINT32: r = VT_UINT32;
                TAG_INT64:  r = VT_INT64;
                TAG_UINT64: r = VT_UINT64;
                TAG_DBL:    r = VT_DBL;
                TAG_DBLX:   r = VT_DBLX;
                TAG_STR:    r = VT_STRING;
                TAG_BLOB:   r = VT_BLOB;
                default:    r = VT_INT32;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

@@ sv/mpp_if.sv @@
`default_nettype none
interface byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface rec_if;
    import mpp_pkg::*;
    logic valid;
    logic ready;
    rec_t rec;
    modport source (output valid, output rec, input ready);
    modport sink (input valid, input rec, output ready);
endinterface
`default_nettype wire

@@ sv/mpp_cfg.sv @@
`default_nettype none
module mpp_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output mpp_pkg::cfg_t    cfg
);
    import mpp_pkg::*;
    cfg_t cfg_reg;
    logic [1:0] idx;
    assign idx = paddr[3:2];
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{max_values: 8'd255, short_type_code: 8'd1, long_type_code: 8'd2};
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            unique case (idx)
                REG_MAXV:  cfg_reg.max_values <= pwdata[7:0];
                REG_SHORT: cfg_reg.short_type_code <= pwdata[7:0];
                REG_LONG:  cfg_reg.long_type_code <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_MAXV:  prdata[7:0] = cfg_reg.max_values;
            REG_SHORT: prdata[7:0] = cfg_reg.short_type_code;
            REG_LONG:  prdata[7:0] = cfg_reg.long_type_code;
            default:   prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

@@ sv/mpp_core.sv @@
`default_nettype none
module mpp_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] b,
    input  wire mpp_pkg::cfg_t cfg,
    output logic            rec_vld,
    output mpp_pkg::rec_t   rec
);
    import mpp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  fbl_reg, fbl_next;
    logic [63:0] asm_reg, asm_next;
    logic [3:0]  tag_reg, tag_next;
    logic [31:0] pbl_reg, pbl_next;
    logic [31:0] pay_reg, pay_next;
    logic [7:0]  vl_reg, vl_next;
    logic [7:0]  vn_reg, vn_next;
    logic [7:0]  str_reg, str_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic        lp_reg, lp_next;
    logic        pws_reg, pws_next;

    logic [3:0]  fbl_dec;
    logic [63:0] asm_sh;
    logic        fdone;
    logic [31:0] pbl_dec;
    logic [31:0] pay_dec;
    logic        is_sync;
    logic        emit;
    logic [2:0]  e_kind, e_vt, e_err;
    logic [63:0] e_data;
    logic [7:0]  e_exp;
    logic        e_last;

    assign is_sync = (b == SYNC_MARK);
    assign asm_sh = {asm_reg[55:0], b};
    assign fbl_dec = (fbl_reg != 4'd0) ? fbl_reg - 4'd1 : 4'd0;
    assign fdone = (fbl_dec == 4'd0);
    assign pbl_dec = (phase_reg >= PH_COUNT && pbl_reg != 32'd0) ? pbl_reg - 32'd1 : pbl_reg;
    assign pay_dec = (pay_reg != 32'd0) ? pay_reg - 32'd1 : 32'd0;

    always_comb
    begin
        phase_next = phase_reg; fbl_next = fbl_reg; asm_next = asm_reg;
        tag_next = tag_reg; pbl_next = pbl_dec; pay_next = pay_reg;
        vl_next = vl_reg; vn_next = vn_reg; str_next = str_reg;
        cnt_next = cnt_reg; lp_next = lp_reg; pws_next = pws_reg;
        emit = 1'b0; e_kind = KIND_START; e_vt = 3'd0; e_data = '0;
        e_exp = '0; e_err = ERR_SYNC; e_last = 1'b0;

        unique case (phase_reg)
            PH_SYNC1:
            begin
                if (!is_sync)
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_SYNC; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = 1'b0;
                end
                else phase_next = PH_SYNC2;
            end
            PH_SYNC2:
            begin
                if (!is_sync)
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_SYNC; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = 1'b0;
                end
                else
                begin
                    phase_next = PH_TYPE; str_next = '0; cnt_next = '0; vn_next = '0;
                end
            end
            PH_HUNT:
            begin
                if (is_sync && pws_reg)
                begin
                    pws_next = 1'b0; phase_next = PH_TYPE;
                    str_next = '0; cnt_next = '0; vn_next = '0;
                end
                else pws_next = is_sync;
            end
            PH_TYPE:
            begin
                if (b == cfg.short_type_code)
                begin
                    lp_next = 1'b0; fbl_next = 4'd2; asm_next = '0; phase_next = PH_LEN;
                end
                else if (b == cfg.long_type_code)
                begin
                    lp_next = 1'b1; fbl_next = 4'd4; asm_next = '0; phase_next = PH_LEN;
                end
                else
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_TYPE; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = is_sync;
                end
            end
            PH_LEN:
            begin
                asm_next = asm_sh; fbl_next = fbl_dec;
                if (fdone)
                begin
                    pbl_next = asm_sh[31:0]; phase_next = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                cnt_next = b; phase_next = PH_STREAM;
            end
            PH_STREAM:
            begin
                str_next = b; vl_next = cnt_reg; vn_next = '0;
                emit = 1'b1;
                if (cnt_reg == 8'd0 || cnt_reg > cfg.max_values)
                begin
                    phase_next = (pbl_dec == 32'd0) ? PH_SYNC1 : PH_SKIP;
                    e_kind = KIND_ERROR; e_last = 1'b1;
                    e_err = (cnt_reg == 8'd0) ? ERR_NOVAL : ERR_TOOMANY;
                end
                else
                begin
                    phase_next = PH_SEQTAG; e_kind = KIND_START;
                    e_data = {32'd0, asm_reg[31:0]};
                end
            end
            PH_SEQTAG:
            begin
                if (b != {4'd0, TAG_INT32A} && b != {4'd0, TAG_INT32B})
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_SEQTAG; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = is_sync;
                end
                else
                begin
                    tag_next = b[3:0]; fbl_next = 4'd4; asm_next = '0; phase_next = PH_SEQVAL;
                end
            end
            PH_SEQVAL:
            begin
                asm_next = asm_sh; fbl_next = fbl_dec;
                if (fdone)
                begin
                    phase_next = PH_TSTAG; emit = 1'b1; e_kind = KIND_SEQNO;
                    e_data = {32'd0, asm_sh[31:0]};
                end
            end
            PH_TSTAG:
            begin
                if (b != {4'd0, TAG_DBL} && b != {4'd0, TAG_DBLX})
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_TSTAG; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = is_sync;
                end
                else
                begin
                    tag_next = b[3:0]; fbl_next = 4'd5; asm_next = '0; phase_next = PH_TSVAL;
                end
            end
            PH_TSVAL:
            begin
                asm_next = asm_sh; fbl_next = fbl_dec;
                if (fdone)
                begin
                    phase_next = PH_VTAG; emit = 1'b1; e_kind = KIND_TSTAMP;
                    e_vt = tag_type(tag_reg); e_data = {32'd0, asm_sh[39:8]};
                    e_exp = asm_sh[7:0];
                end
            end
            PH_VTAG:
            begin
                tag_next = b[3:0];
                priority if (b == {4'd0, TAG_INT32A} || b == {4'd0, TAG_INT32B}
                             || b == {4'd0, TAG_UINT32})
                begin
                    fbl_next = 4'd4; asm_next = '0; phase_next = PH_VDATA;
                end
                else if (b == {4'd0, TAG_INT64} || b == {4'd0, TAG_UINT64})
                begin
                    fbl_next = 4'd8; asm_next = '0; phase_next = PH_VDATA;
                end
                else if (b == {4'd0, TAG_DBL} || b == {4'd0, TAG_DBLX})
                begin
                    fbl_next = 4'd5; asm_next = '0; phase_next = PH_VDATA;
                end
                else if (b == {4'd0, TAG_STR})
                    phase_next = PH_SLEN;
                else if (b == {4'd0, TAG_BLOB})
                begin
                    fbl_next = 4'd4; asm_next = '0; phase_next = PH_BLEN;
                end
                else
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_TAG; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = is_sync;
                end
            end
            PH_VDATA:
            begin
                asm_next = asm_sh; fbl_next = fbl_dec;
                if (fdone)
                begin
                    emit = 1'b1; e_kind = KIND_VALUE; e_vt = tag_type(tag_reg);
                    if (tag_reg == TAG_DBL || tag_reg == TAG_DBLX)
                    begin
                        e_data = {32'd0, asm_sh[39:8]}; e_exp = asm_sh[7:0];
                    end
                    else e_data = asm_sh;
                    e_last = (vl_reg <= 8'd1);
                    if (vl_reg != 8'd0) vl_next = vl_reg - 8'd1;
                    vn_next = vn_reg + 8'd1;
                    phase_next = e_last ? PH_SYNC1 : PH_VTAG;
                end
            end
            PH_SLEN:
            begin
                if (b > STR_MAX)
                begin
                    emit = 1'b1; e_kind = KIND_ERROR; e_err = ERR_TAG; e_last = 1'b1;
                    phase_next = PH_HUNT; pws_next = is_sync;
                end
                else
                begin
                    pay_next = {24'd0, b}; emit = 1'b1; e_kind = KIND_VALUE;
                    e_vt = VT_STRING; e_data = {56'd0, b};
                    if (b == 8'd0)
                    begin
                        e_last = (vl_reg <= 8'd1);
                        if (vl_reg != 8'd0) vl_next = vl_reg - 8'd1;
                        vn_next = vn_reg + 8'd1;
                        phase_next = e_last ? PH_SYNC1 : PH_VTAG;
                    end
                    else phase_next = PH_PAY;
                end
            end
            PH_BLEN:
            begin
                asm_next = asm_sh; fbl_next = fbl_dec;
                if (fdone)
                begin
                    emit = 1'b1;
                    if (asm_sh[31:0] > pbl_dec)
                    begin
                        e_kind = KIND_ERROR; e_err = ERR_BLOB; e_last = 1'b1;
                        phase_next = PH_HUNT; pws_next = is_sync;
                    end
                    else
                    begin
                        pay_next = asm_sh[31:0]; e_kind = KIND_VALUE; e_vt = VT_BLOB;
                        e_data = {32'd0, asm_sh[31:0]};
                        if (asm_sh[31:0] == 32'd0)
                        begin
                            e_last = (vl_reg <= 8'd1);
                            if (vl_reg != 8'd0) vl_next = vl_reg - 8'd1;
                            vn_next = vn_reg + 8'd1;
                            phase_next = e_last ? PH_SYNC1 : PH_VTAG;
                        end
                        else phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                pay_next = pay_dec; emit = 1'b1; e_kind = KIND_PAYLOAD;
                e_vt = tag_type(tag_reg); e_data = {56'd0, b};
                if (pay_dec == 32'd0)
                begin
                    e_last = (vl_reg <= 8'd1);
                    if (vl_reg != 8'd0) vl_next = vl_reg - 8'd1;
                    vn_next = vn_reg + 8'd1;
                    phase_next = e_last ? PH_SYNC1 : PH_VTAG;
                end
            end
            PH_SKIP:
            begin
                if (pbl_dec == 32'd0) phase_next = PH_SYNC1;
            end
            default: phase_next = PH_SYNC1;
        endcase
    end

    // Stream index and packet count fields use register values as updated by this byte
    always_comb
    begin
        rec.rec_kind = e_kind; rec.value_type = e_vt; rec.data_value = e_data;
        rec.exponent = e_exp; rec.stream_index = str_next; rec.pkt_count = cnt_next;
        rec.value_index = vn_reg; rec.error_code = (e_kind == KIND_ERROR) ? e_err : 3'd0;
        rec.last = e_last;
        rec_vld = step && emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1; fbl_reg <= '0; asm_reg <= '0; tag_reg <= '0;
            pbl_reg <= '0; pay_reg <= '0; vl_reg <= '0; vn_reg <= '0;
            str_reg <= '0; cnt_reg <= '0; lp_reg <= 1'b0; pws_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next; fbl_reg <= fbl_next; asm_reg <= asm_next;
            tag_reg <= tag_next; pbl_reg <= pbl_next; pay_reg <= pay_next;
            vl_reg <= vl_next; vn_reg <= vn_next; str_reg <= str_next;
            cnt_reg <= cnt_next; lp_reg <= lp_next; pws_reg <= pws_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rec_vld && rec.rec_kind == KIND_ERROR |-> rec.last)
        else $error("error result without last");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_HUNT |-> !emit)
        else $error("result while hunting for sync");
    assert property (@(posedge clk) disable iff (!rst_n)
        step && rec_vld && rec.last |=> phase_reg == PH_SYNC1 || phase_reg == PH_HUNT
        || phase_reg == PH_SKIP)
        else $error("packet end did not return to sync search");
endmodule
`default_nettype wire

@@ sv/measurement_packet_parser.sv @@
`default_nettype none
// Measurement packet parser: one stream byte per word in, at most one record out.
// Throughput: one byte per cycle unless out_ch stalls; mpp_core updates in one pass.
// Latency: a record appears on the output register the cycle after its byte is taken.
// The input is ready whenever the output register is empty or being drained.
// Reset (rst_n low, asynchronous) returns to sync search and loads the default registers.
module measurement_packet_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    byte_if.sink             in_ch,
    rec_if.source            out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mpp_pkg::*;

    cfg_t cfg;
    logic step;
    logic rec_vld;
    rec_t rec;
    logic out_vld_reg;
    rec_t out_rec_reg;

    mpp_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    // Accept a new word when the result register is free or draining this cycle
    assign in_ch.ready = !out_vld_reg || out_ch.ready;
    assign step = in_ch.valid && in_ch.ready;

    mpp_core u_core (
        .clk(clk), .rst_n(rst_n), .step(step), .b(in_ch.in_byte), .cfg(cfg),
        .rec_vld(rec_vld), .rec(rec)
    );

    // Hold the record until taken, then load the next one or drop valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (in_ch.ready)
            out_vld_reg <= rec_vld;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && rec_vld)
            out_rec_reg <= rec;
    end

    assign out_ch.valid = out_vld_reg;
    assign out_ch.rec = out_rec_reg;
endmodule
`default_nettype wire
